>>> hdl/bmis_pkg.sv
// shared types and constants for the body motion integration step
`timescale 1ns / 1ps

package bmis_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RateW    = 20;
  localparam int unsigned VelCfgW  = 31;
  localparam int unsigned TickW    = 16;
  localparam int unsigned WishW    = 16;
  localparam int unsigned SpeedW   = 31;
  localparam int unsigned WishFrac = 14;
  localparam int unsigned TickFrac = 16;

  // multiplier operands and accumulator
  localparam int unsigned OpW    = 33;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned AccW   = ProdW + 2;
  // tick times 30 and the blend coefficient before the control scale
  localparam int unsigned T30W   = TickW + 5;
  localparam int unsigned CoefW  = RateW + T30W;
  localparam int unsigned SplitW = 24;

  typedef struct packed {
    logic [RateW-1:0]   speed_factor;
    logic [RateW-1:0]   air_control;
    logic [RateW-1:0]   accel_rate;
    logic [RateW-1:0]   decel_rate;
    logic [VelCfgW-1:0] jump_velocity;
    logic [VelCfgW-1:0] gravity;
    logic [TickW-1:0]   tick_step;
  } cfg_t;

  typedef enum logic [2:0] {
    SH_NONE,
    SH_WISH,
    SH_TICK,
    SH_FRAC,
    SH_BLEND
  } shift_e;

  typedef struct packed {
    logic   first;
    logic   neg;
    logic   hi;
    shift_e sh;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [31:0] sat;
    logic               pos;
    logic [CoefW-1:0]   raw;
  } mac_res_t;

endpackage

>>> hdl/bmis_cfg.sv
// configuration register bank
`timescale 1ns / 1ps

module bmis_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bmis_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bmis_pkg::CfgDataW-1:0] cfg_data_i,
  output bmis_pkg::cfg_t                cfg_o
);
  import bmis_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPEED_FACTOR  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AIR_CONTROL   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_RATE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DECEL_RATE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_JUMP_VELOCITY = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TICK_STEP     = 3'd6;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SPEED_FACTOR:  cfg_d.speed_factor  = cfg_data_i[RateW-1:0];
        CFG_AIR_CONTROL:   cfg_d.air_control   = cfg_data_i[RateW-1:0];
        CFG_ACCEL_RATE:    cfg_d.accel_rate    = cfg_data_i[RateW-1:0];
        CFG_DECEL_RATE:    cfg_d.decel_rate    = cfg_data_i[RateW-1:0];
        CFG_JUMP_VELOCITY: cfg_d.jump_velocity = cfg_data_i[VelCfgW-1:0];
        CFG_GRAVITY:       cfg_d.gravity       = cfg_data_i[VelCfgW-1:0];
        CFG_TICK_STEP:     cfg_d.tick_step     = cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_factor  <= RateW'(65536);
      cfg_q.air_control   <= RateW'(6554);
      cfg_q.accel_rate    <= RateW'(13107);
      cfg_q.decel_rate    <= RateW'(26214);
      cfg_q.jump_velocity <= VelCfgW'(327680);
      cfg_q.gravity       <= VelCfgW'(642908);
      cfg_q.tick_step     <= TickW'(2185);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/bmis_mac.sv
// shared multiply-accumulate unit with rounding shift and saturation
`timescale 1ns / 1ps

module bmis_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            mul_en_i,
  input  logic                            acc_en_i,
  input  bmis_pkg::mac_ctl_t              ctl_i,
  input  logic signed [bmis_pkg::OpW-1:0] a_i,
  input  logic signed [bmis_pkg::OpW-1:0] b_i,
  input  logic signed [31:0]              base_i,
  output bmis_pkg::mac_res_t              res_o,
  output logic [FRAC_BITS:0]              blend_o
);
  import bmis_pkg::*;

  function automatic int unsigned sh_amt(shift_e s);
    int unsigned r;
    case (s)
      SH_NONE:  r = 0;
      SH_WISH:  r = WishFrac;
      SH_TICK:  r = TickFrac;
      SH_FRAC:  r = FRAC_BITS;
      SH_BLEND: r = FRAC_BITS + TickFrac;
      default:  r = 0;
    endcase
    return r;
  endfunction

  logic signed [ProdW-1:0] prod_q;
  logic [AccW-1:0]         acc_q, acc_d;
  shift_e                  sh_q;

  logic [5:0]      amt_c, amt_f;
  logic [AccW-1:0] half_v, base_ext, init_v, prod_ext, prod_sh, start_v, rnd_v;
  logic            fits;

  assign amt_c = 6'(sh_amt(ctl_i.sh));
  assign amt_f = 6'(sh_amt(sh_q));

  // rounding offset, one less when the product is subtracted from the base
  always_comb begin
    half_v = '0;
    if (amt_c != 6'd0) begin
      half_v = AccW'(1) << (amt_c - 6'd1);
      if (ctl_i.neg) begin
        half_v = half_v - AccW'(1);
      end
    end
  end

  assign base_ext = AccW'(base_i);
  assign init_v   = (base_ext << amt_c) + half_v;
  assign prod_ext = AccW'(prod_q);
  assign prod_sh  = ctl_i.hi ? (prod_ext << SplitW) : prod_ext;
  assign start_v  = ctl_i.first ? init_v : acc_q;
  assign acc_d    = ctl_i.neg ? (start_v - prod_sh) : (start_v + prod_sh);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= a_i * b_i;
    end
    if (acc_en_i) begin
      acc_q <= acc_d;
      sh_q  <= ctl_i.sh;
    end
  end

  assign rnd_v = $signed(acc_q) >>> amt_f;
  assign fits  = (&rnd_v[AccW-1:31]) | ~(|rnd_v[AccW-1:31]);

  always_comb begin
    if (fits) begin
      res_o.sat = rnd_v[31:0];
    end else if (rnd_v[AccW-1]) begin
      res_o.sat = 32'sh8000_0000;
    end else begin
      res_o.sat = 32'sh7fff_ffff;
    end
    res_o.pos = ~acc_q[AccW-1] & (|acc_q);
    res_o.raw = acc_q[CoefW-1:0];
  end

  // blend is never negative; cap at one
  assign blend_o = (|rnd_v[AccW-1:FRAC_BITS]) ? {1'b1, {FRAC_BITS{1'b0}}}
                                              : {1'b0, rnd_v[FRAC_BITS-1:0]};

endmodule

>>> hdl/body_motion_integration_step_core.sv
// top level: body state, sequencer and output register of the motion step
`timescale 1ns / 1ps

// Advances one body (position, velocity, on-ground flag) by one tick per item.
// Input channel: in_valid_i / in_stall_o with wish direction, max speed, jump
// request and ground height; an item is taken when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i with new position, velocity and the
// grounded flag, one result per input item, held in an output register.
// Configuration: cfg_valid_i / cfg_ready_o with register index and data, always
// ready; write only while no item is in flight.
// Sequencing: in_stall_o is high from acceptance until out_valid_o rises, so
// a new item is taken only after the previous one has left the sequencer. The
// time is set by the single 33x33 multiply-accumulate unit: up to sixteen
// products (gravity adds one when the body starts airborne), each passing a
// multiply state and an accumulate state, plus a write back state after the
// last part of an operation, then a clamp state and an output state.
// The next item is accepted while a result waits in the output register; if
// the receiver still stalls when the next result is ready, the block holds.
// Reset: position and velocity go to zero, the body rests on ground, the
// configuration registers take their defaults and no result is pending.

module body_motion_integration_step_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            wish_x_i,
  input  logic signed [15:0]            wish_z_i,
  input  logic [bmis_pkg::SpeedW-1:0]   max_speed_i,
  input  logic                          jump_i,
  input  logic signed [31:0]            ground_height_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic signed [31:0]            pos_z_o,
  output logic signed [31:0]            vel_x_o,
  output logic signed [31:0]            vel_y_o,
  output logic signed [31:0]            vel_z_o,
  output logic                          grounded_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bmis_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bmis_pkg::CfgDataW-1:0] cfg_data_i
);
  import bmis_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_WR    = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [3:0] OP_TSPEED = 4'd0;
  localparam logic [3:0] OP_TX     = 4'd1;
  localparam logic [3:0] OP_TZ     = 4'd2;
  localparam logic [3:0] OP_SQ_TX  = 4'd3;
  localparam logic [3:0] OP_SQ_TZ  = 4'd4;
  localparam logic [3:0] OP_SQ_VX  = 4'd5;
  localparam logic [3:0] OP_SQ_VZ  = 4'd6;
  localparam logic [3:0] OP_COEF   = 4'd7;
  localparam logic [3:0] OP_BL_LO  = 4'd8;
  localparam logic [3:0] OP_BL_HI  = 4'd9;
  localparam logic [3:0] OP_VX     = 4'd10;
  localparam logic [3:0] OP_VZ     = 4'd11;
  localparam logic [3:0] OP_VY     = 4'd12;
  localparam logic [3:0] OP_PX     = 4'd13;
  localparam logic [3:0] OP_PY     = 4'd14;
  localparam logic [3:0] OP_PZ     = 4'd15;

  localparam logic [FRAC_BITS:0] BLEND_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  cfg_t cfg;

  logic [2:0] state_q, state_d;
  logic [3:0] op_q, op_d;

  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic               og_q, og_d;

  logic signed [WishW-1:0] wx_q, wx_d, wz_q, wz_d;
  logic [SpeedW-1:0]       ms_q, ms_d;
  logic                    jump_q, jump_d;
  logic signed [31:0]      gnd_q, gnd_d;

  logic signed [31:0] tspeed_q, tspeed_d, tx_q, tx_d, tz_q, tz_d;
  logic               accel_q, accel_d;
  logic [CoefW-1:0]   coef_q, coef_d;
  logic [FRAC_BITS:0] blend_q, blend_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] opx_q, opx_d, opy_q, opy_d, opz_q, opz_d;
  logic signed [31:0] ovx_q, ovx_d, ovy_q, ovy_d, ovz_q, ovz_d;
  logic               ogr_q, ogr_d;

  mac_ctl_t              ctl;
  mac_res_t              res;
  logic signed [OpW-1:0] op_a, op_b;
  logic signed [31:0]    base;
  logic                  last;
  logic [FRAC_BITS:0]    blend_res;
  logic [T30W-1:0]       t30;
  logic [OpW-1:0]        ctrl;
  logic [OpW-1:0]        tick_op;

  bmis_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bmis_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .mul_en_i (state_q == ST_MUL),
    .acc_en_i (state_q == ST_ACC),
    .ctl_i    (ctl),
    .a_i      (op_a),
    .b_i      (op_b),
    .base_i   (base),
    .res_o    (res),
    .blend_o  (blend_res)
  );

  // tick times 30 by shift and subtract
  assign t30     = (T30W'(cfg.tick_step) << 5) - (T30W'(cfg.tick_step) << 1);
  assign ctrl    = og_q ? (OpW'(1) << FRAC_BITS) : OpW'(cfg.air_control);
  assign tick_op = OpW'(cfg.tick_step);

  // operand and control selection per operation
  always_comb begin
    op_a = '0;
    op_b = '0;
    base = '0;
    last = 1'b1;
    ctl  = '{first: 1'b1, neg: 1'b0, hi: 1'b0, sh: SH_NONE};
    case (op_q)
      OP_TSPEED: begin
        op_a   = OpW'(ms_q);
        op_b   = OpW'(cfg.speed_factor);
        ctl.sh = SH_FRAC;
      end
      OP_TX: begin
        op_a   = OpW'(wx_q);
        op_b   = OpW'(tspeed_q);
        ctl.sh = SH_WISH;
      end
      OP_TZ: begin
        op_a   = OpW'(wz_q);
        op_b   = OpW'(tspeed_q);
        ctl.sh = SH_WISH;
      end
      OP_SQ_TX: begin
        op_a = OpW'(tx_q);
        op_b = OpW'(tx_q);
        last = 1'b0;
      end
      OP_SQ_TZ: begin
        op_a      = OpW'(tz_q);
        op_b      = OpW'(tz_q);
        ctl.first = 1'b0;
        last      = 1'b0;
      end
      OP_SQ_VX: begin
        op_a      = OpW'(vx_q);
        op_b      = OpW'(vx_q);
        ctl.first = 1'b0;
        ctl.neg   = 1'b1;
        last      = 1'b0;
      end
      OP_SQ_VZ: begin
        op_a      = OpW'(vz_q);
        op_b      = OpW'(vz_q);
        ctl.first = 1'b0;
        ctl.neg   = 1'b1;
      end
      OP_COEF: begin
        op_a = accel_q ? OpW'(cfg.accel_rate) : OpW'(cfg.decel_rate);
        op_b = OpW'(t30);
      end
      OP_BL_LO: begin
        op_a   = OpW'(coef_q[SplitW-1:0]);
        op_b   = ctrl;
        ctl.sh = SH_BLEND;
        last   = 1'b0;
      end
      OP_BL_HI: begin
        op_a      = OpW'(coef_q[CoefW-1:SplitW]);
        op_b      = ctrl;
        ctl.first = 1'b0;
        ctl.hi    = 1'b1;
        ctl.sh    = SH_BLEND;
      end
      OP_VX: begin
        op_a   = OpW'(tx_q) - OpW'(vx_q);
        op_b   = OpW'(blend_q);
        base   = vx_q;
        ctl.sh = SH_FRAC;
      end
      OP_VZ: begin
        op_a   = OpW'(tz_q) - OpW'(vz_q);
        op_b   = OpW'(blend_q);
        base   = vz_q;
        ctl.sh = SH_FRAC;
      end
      OP_VY: begin
        op_a    = OpW'(cfg.gravity);
        op_b    = tick_op;
        base    = vy_q;
        ctl.neg = 1'b1;
        ctl.sh  = SH_TICK;
      end
      OP_PX: begin
        op_a   = OpW'(vx_q);
        op_b   = tick_op;
        base   = px_q;
        ctl.sh = SH_TICK;
      end
      OP_PY: begin
        op_a   = OpW'(vy_q);
        op_b   = tick_op;
        base   = py_q;
        ctl.sh = SH_TICK;
      end
      OP_PZ: begin
        op_a   = OpW'(vz_q);
        op_b   = tick_op;
        base   = pz_q;
        ctl.sh = SH_TICK;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // sequencer and state update
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    vz_d        = vz_q;
    og_d        = og_q;
    wx_d        = wx_q;
    wz_d        = wz_q;
    ms_d        = ms_q;
    jump_d      = jump_q;
    gnd_d       = gnd_q;
    tspeed_d    = tspeed_q;
    tx_d        = tx_q;
    tz_d        = tz_q;
    accel_d     = accel_q;
    coef_d      = coef_q;
    blend_d     = blend_q;
    out_valid_d = out_valid_q & out_stall_i;
    opx_d       = opx_q;
    opy_d       = opy_q;
    opz_d       = opz_q;
    ovx_d       = ovx_q;
    ovy_d       = ovy_q;
    ovz_d       = ovz_q;
    ogr_d       = ogr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          wx_d    = wish_x_i;
          wz_d    = wish_z_i;
          ms_d    = max_speed_i;
          jump_d  = jump_i;
          gnd_d   = ground_height_i;
          op_d    = OP_TSPEED;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (last) begin
          state_d = ST_WR;
        end else begin
          op_d    = op_q + 4'd1;
          state_d = ST_MUL;
        end
      end
      ST_WR: begin
        op_d    = op_q + 4'd1;
        state_d = ST_MUL;
        case (op_q)
          OP_TSPEED: tspeed_d = res.sat;
          OP_TX:     tx_d     = res.sat;
          OP_TZ:     tz_d     = res.sat;
          OP_SQ_VZ:  accel_d  = res.pos;
          OP_COEF:   coef_d   = res.raw;
          OP_BL_HI:  blend_d  = blend_res;
          OP_VX:     vx_d     = res.sat;
          OP_VZ: begin
            vz_d = res.sat;
            // on ground gravity is skipped; a jump sets the vertical velocity
            if (og_q) begin
              if (jump_q) begin
                vy_d = $signed({1'b0, cfg.jump_velocity});
                og_d = 1'b0;
              end
              op_d = OP_PX;
            end
          end
          OP_VY:     vy_d     = res.sat;
          OP_PX:     px_d     = res.sat;
          OP_PY:     py_d     = res.sat;
          OP_PZ: begin
            pz_d    = res.sat;
            state_d = ST_CLAMP;
          end
          default: ;
        endcase
      end
      ST_CLAMP: begin
        if (py_q <= gnd_q) begin
          py_d = gnd_q;
          if (vy_q[31]) begin
            vy_d = '0;
          end
          og_d = 1'b1;
        end else begin
          og_d = 1'b0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          opx_d       = px_q;
          opy_d       = py_q;
          opz_d       = pz_q;
          ovx_d       = vx_q;
          ovy_d       = vy_q;
          ovz_d       = vz_q;
          ogr_d       = og_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_TSPEED;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
      og_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      px_q        <= px_d;
      py_q        <= py_d;
      pz_q        <= pz_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      vz_q        <= vz_d;
      og_q        <= og_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q     <= wx_d;
    wz_q     <= wz_d;
    ms_q     <= ms_d;
    jump_q   <= jump_d;
    gnd_q    <= gnd_d;
    tspeed_q <= tspeed_d;
    tx_q     <= tx_d;
    tz_q     <= tz_d;
    accel_q  <= accel_d;
    coef_q   <= coef_d;
    blend_q  <= blend_d;
    opx_q    <= opx_d;
    opy_q    <= opy_d;
    opz_q    <= opz_d;
    ovx_q    <= ovx_d;
    ovy_q    <= ovy_d;
    ovz_q    <= ovz_d;
    ogr_q    <= ogr_d;
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = opx_q;
  assign pos_y_o     = opy_q;
  assign pos_z_o     = opz_q;
  assign vel_x_o     = ovx_q;
  assign vel_y_o     = ovy_q;
  assign vel_z_o     = ovz_q;
  assign grounded_o  = ogr_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL && op_q == OP_TSPEED))
    else $error("item accepted but sequencer did not start");

  a_blend_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR && op_q == OP_BL_HI) |=> (blend_q <= BLEND_ONE))
    else $error("blend coefficient above one");

  a_ground_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP) |=> ((og_q == (py_q == gnd_q)) && (!og_q || !vy_q[31])))
    else $error("ground contact inconsistent");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside of completion");

endmodule
